### src/seq_pkg.sv
// ----------------------------------------------------------------------------
// seq_pkg: shared types and constants for the sorted expiry queue
// Entry payload layout, per-cell control group, opcodes and default sizes.
// ----------------------------------------------------------------------------
package seq_pkg;

  // default sizing
  localparam int CAPACITY_DEF  = 64;
  localparam int TIME_BITS_DEF = 32;

  // request opcodes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // payload held by one cell, fixed widths
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic        [15:0] radius;
    logic        [31:0] color;
  } entry_data_t;

  // broadcast control to every cell of the chain
  typedef struct packed {
    logic insert;      // sorted insert of the new entry
    logic shift_left;  // drop the head, everything moves one towards the head
    logic lane_load;   // copy entries into the read lane
    logic lane_shift;  // read lane moves one towards the head
  } cell_ctrl_t;

endpackage

### src/seq_cell.sv
// ----------------------------------------------------------------------------
// seq_cell: one slot of the sorted chain
// Holds one entry and one read-lane word; swaps data with its neighbours
// under the broadcast control.
// ----------------------------------------------------------------------------
module seq_cell #(
  parameter int TIME_BITS = seq_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  seq_pkg::cell_ctrl_t   ctrl,
  input  logic [TIME_BITS-1:0]  new_expiry,
  input  seq_pkg::entry_data_t  new_data,
  // neighbour towards the head
  input  logic                  left_valid,
  input  logic [TIME_BITS-1:0]  left_expiry,
  input  seq_pkg::entry_data_t  left_data,
  input  logic                  left_ge,
  // neighbour towards the tail
  input  logic                  right_valid,
  input  logic [TIME_BITS-1:0]  right_expiry,
  input  seq_pkg::entry_data_t  right_data,
  input  logic [TIME_BITS-1:0]  right_lane_expiry,
  input  seq_pkg::entry_data_t  right_lane_data,
  // own state
  output logic                  valid,
  output logic [TIME_BITS-1:0]  expiry,
  output seq_pkg::entry_data_t  data,
  output logic                  ge,
  output logic [TIME_BITS-1:0]  lane_expiry,
  output seq_pkg::entry_data_t  lane_data
);

  logic                  valid_r, valid_nxt;
  logic [TIME_BITS-1:0]  expiry_r, expiry_nxt;
  seq_pkg::entry_data_t  data_r, data_nxt;
  logic [TIME_BITS-1:0]  lane_expiry_r, lane_expiry_nxt;
  seq_pkg::entry_data_t  lane_data_r, lane_data_nxt;

  // empty slots count as later than anything
  assign ge = !valid_r || (expiry_r >= new_expiry);

  // entry update
  always_comb begin
    valid_nxt  = valid_r;
    expiry_nxt = expiry_r;
    data_nxt   = data_r;
    if (ctrl.insert && ge) begin
      if (left_ge) begin
        valid_nxt  = left_valid;
        expiry_nxt = left_expiry;
        data_nxt   = left_data;
      end else begin
        valid_nxt  = 1'b1;
        expiry_nxt = new_expiry;
        data_nxt   = new_data;
      end
    end else if (ctrl.shift_left) begin
      valid_nxt  = right_valid;
      expiry_nxt = right_expiry;
      data_nxt   = right_data;
    end
  end

  // read lane update
  always_comb begin
    lane_expiry_nxt = lane_expiry_r;
    lane_data_nxt   = lane_data_r;
    if (ctrl.lane_load) begin
      lane_expiry_nxt = expiry_r;
      lane_data_nxt   = data_r;
    end else if (ctrl.lane_shift) begin
      lane_expiry_nxt = right_lane_expiry;
      lane_data_nxt   = right_lane_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    expiry_r      <= expiry_nxt;
    data_r        <= data_nxt;
    lane_expiry_r <= lane_expiry_nxt;
    lane_data_r   <= lane_data_nxt;
  end

  assign valid       = valid_r;
  assign expiry      = expiry_r;
  assign data        = data_r;
  assign lane_expiry = lane_expiry_r;
  assign lane_data   = lane_data_r;

endmodule

### src/sorted_expiry_queue.sv
// ----------------------------------------------------------------------------
// sorted_expiry_queue: bounded queue of timed entries sorted by expiry
// A chain of CAPACITY cells, head first, kept in expiry order.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with out_valid high, and the
// receiver cannot stall it. Work from accept to the next possible accept:
// insert does the saturating add, then one parallel compare-and-shift of the
// chain; a full-queue insert, a no-op or a read past the live entries finish
// at accept; advance removes the expired entries (the chain drops one head
// entry per cycle); read of a live entry loads the read lane and walks it
// read_index slots (the read lane shifts one slot towards the head per cycle).
// The result is registered, in the cycle after the last working cycle. No
// clearing pass is needed after reset.
module sorted_expiry_queue #(
  parameter int CAPACITY  = seq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = seq_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic [15:0]        in_size_radius,
  input  logic [31:0]        in_rgba_color,
  input  logic [31:0]        in_lifetime,
  input  logic [31:0]        in_tick_count,
  input  logic [5:0]         in_read_index,
  output logic               out_valid,
  output logic [6:0]         out_live_count,
  output logic [31:0]        out_now_time,
  output logic               out_insert_dropped,
  output logic [6:0]         out_expired_count,
  output logic               out_read_valid,
  output logic signed [23:0] out_read_x,
  output logic signed [23:0] out_read_y,
  output logic [15:0]        out_read_radius,
  output logic [31:0]        out_read_color,
  output logic [31:0]        out_read_expiry
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam int EXT_W = CNT_W + 7;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_ADV  = 2'd2;
  localparam logic [1:0] ST_RD   = 2'd3;

  localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'({TIME_BITS{1'b1}});

  logic [1:0]            state_r, state_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      expired_r, expired_nxt;
  logic [5:0]            rd_cnt_r, rd_cnt_nxt;
  logic [TIME_BITS-1:0]  new_expiry_r, new_expiry_nxt;
  seq_pkg::entry_data_t  new_data_r, new_data_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]      out_live_r, out_live_nxt;
  logic [TIME_BITS-1:0]  out_now_r, out_now_nxt;
  logic                  out_drop_r, out_drop_nxt;
  logic [CNT_W-1:0]      out_exp_cnt_r, out_exp_cnt_nxt;
  logic                  out_rd_valid_r, out_rd_valid_nxt;
  seq_pkg::entry_data_t  out_data_r, out_data_nxt;
  logic [TIME_BITS-1:0]  out_expiry_r, out_expiry_nxt;

  seq_pkg::cell_ctrl_t   ctrl;
  logic                  accept;

  logic                  cell_valid  [CAPACITY];
  logic [TIME_BITS-1:0]  cell_expiry [CAPACITY];
  seq_pkg::entry_data_t  cell_data   [CAPACITY];
  logic                  cell_ge     [CAPACITY];
  logic [TIME_BITS-1:0]  lane_expiry [CAPACITY];
  seq_pkg::entry_data_t  lane_data   [CAPACITY];

  // saturating add shared by insert (lifetime) and advance (tick count)
  logic [31:0]           add_b;
  logic [SUM_W-1:0]      sum_w;
  logic [TIME_BITS-1:0]  sum_sat;

  assign add_b   = (in_opcode == seq_pkg::OP_INSERT) ? in_lifetime : in_tick_count;
  assign sum_w   = SUM_W'(now_r) + SUM_W'(add_b);
  assign sum_sat = (sum_w > TIME_MAX) ? {TIME_BITS{1'b1}} : sum_w[TIME_BITS-1:0];

  assign accept = start && !busy;

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_valid, l_ge, r_valid;
    logic [TIME_BITS-1:0]  l_expiry, r_expiry, r_lane_expiry;
    seq_pkg::entry_data_t  l_data, r_data, r_lane_data;

    if (i == 0) begin : g_head
      assign l_valid  = 1'b0;
      assign l_ge     = 1'b0;
      assign l_expiry = '0;
      assign l_data   = '0;
    end else begin : g_mid
      assign l_valid  = cell_valid[i-1];
      assign l_ge     = cell_ge[i-1];
      assign l_expiry = cell_expiry[i-1];
      assign l_data   = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid       = 1'b0;
      assign r_expiry      = '0;
      assign r_data        = '0;
      assign r_lane_expiry = '0;
      assign r_lane_data   = '0;
    end else begin : g_body
      assign r_valid       = cell_valid[i+1];
      assign r_expiry      = cell_expiry[i+1];
      assign r_data        = cell_data[i+1];
      assign r_lane_expiry = lane_expiry[i+1];
      assign r_lane_data   = lane_data[i+1];
    end

    seq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk               (clk),
      .rst_n             (rst_n),
      .ctrl              (ctrl),
      .new_expiry        (new_expiry_r),
      .new_data          (new_data_r),
      .left_valid        (l_valid),
      .left_expiry       (l_expiry),
      .left_data         (l_data),
      .left_ge           (l_ge),
      .right_valid       (r_valid),
      .right_expiry      (r_expiry),
      .right_data        (r_data),
      .right_lane_expiry (r_lane_expiry),
      .right_lane_data   (r_lane_data),
      .valid             (cell_valid[i]),
      .expiry            (cell_expiry[i]),
      .data              (cell_data[i]),
      .ge                (cell_ge[i]),
      .lane_expiry       (lane_expiry[i]),
      .lane_data         (lane_data[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    now_nxt          = now_r;
    count_nxt        = count_r;
    expired_nxt      = expired_r;
    rd_cnt_nxt       = rd_cnt_r;
    new_expiry_nxt   = new_expiry_r;
    new_data_nxt     = new_data_r;
    ctrl             = '0;
    out_valid_nxt    = 1'b0;
    out_live_nxt     = out_live_r;
    out_now_nxt      = out_now_r;
    out_drop_nxt     = out_drop_r;
    out_exp_cnt_nxt  = out_exp_cnt_r;
    out_rd_valid_nxt = out_rd_valid_r;
    out_data_nxt     = out_data_r;
    out_expiry_nxt   = out_expiry_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // default status result, finished here for the requests that end at accept
          out_live_nxt     = count_r;
          out_now_nxt      = now_r;
          out_drop_nxt     = 1'b0;
          out_exp_cnt_nxt  = '0;
          out_rd_valid_nxt = 1'b0;
          out_data_nxt     = '0;
          out_expiry_nxt   = '0;
          case (in_opcode)
            seq_pkg::OP_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                out_drop_nxt  = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                new_expiry_nxt = sum_sat;
                new_data_nxt   = '{x: in_pos_x, y: in_pos_y,
                                   radius: in_size_radius, color: in_rgba_color};
                state_nxt      = ST_INS;
              end
            end
            seq_pkg::OP_ADVANCE: begin
              now_nxt     = sum_sat;
              expired_nxt = '0;
              state_nxt   = ST_ADV;
            end
            seq_pkg::OP_READ: begin
              if (EXT_W'(in_read_index) < EXT_W'(count_r)) begin
                ctrl.lane_load = 1'b1;
                rd_cnt_nxt     = in_read_index;
                state_nxt      = ST_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_INS: begin
        ctrl.insert   = 1'b1;
        count_nxt     = count_r + 1'b1;
        out_live_nxt  = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      // drop expired entries from the head, one a cycle
      ST_ADV: begin
        if (cell_valid[0] && (cell_expiry[0] < now_r)) begin
          ctrl.shift_left = 1'b1;
          count_nxt       = count_r - 1'b1;
          expired_nxt     = expired_r + 1'b1;
        end else begin
          out_live_nxt    = count_r;
          out_now_nxt     = now_r;
          out_exp_cnt_nxt = expired_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end

      // walk the read lane until the wanted entry sits at the head
      ST_RD: begin
        if (rd_cnt_r == '0) begin
          out_rd_valid_nxt = 1'b1;
          out_data_nxt     = lane_data[0];
          out_expiry_nxt   = lane_expiry[0];
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          ctrl.lane_shift = 1'b1;
          rd_cnt_nxt      = rd_cnt_r - 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    expired_r      <= expired_nxt;
    rd_cnt_r       <= rd_cnt_nxt;
    new_expiry_r   <= new_expiry_nxt;
    new_data_r     <= new_data_nxt;
    out_live_r     <= out_live_nxt;
    out_now_r      <= out_now_nxt;
    out_drop_r     <= out_drop_nxt;
    out_exp_cnt_r  <= out_exp_cnt_nxt;
    out_rd_valid_r <= out_rd_valid_nxt;
    out_data_r     <= out_data_nxt;
    out_expiry_r   <= out_expiry_nxt;
  end

  // result ports, time and counts cut or widened to the port widths
  logic [EXT_W-1:0] live_ext, exp_ext;
  logic [SUM_W-1:0] now_ext, expiry_ext;

  assign live_ext   = EXT_W'(out_live_r);
  assign exp_ext    = EXT_W'(out_exp_cnt_r);
  assign now_ext    = SUM_W'(out_now_r);
  assign expiry_ext = SUM_W'(out_expiry_r);

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_live_count     = live_ext[6:0];
  assign out_now_time       = now_ext[31:0];
  assign out_insert_dropped = out_drop_r;
  assign out_expired_count  = exp_ext[6:0];
  assign out_read_valid     = out_rd_valid_r;
  assign out_read_x         = out_data_r.x;
  assign out_read_y         = out_data_r.y;
  assign out_read_radius    = out_data_r.radius;
  assign out_read_color     = out_data_r.color;
  assign out_read_expiry    = expiry_ext[31:0];

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |-> (count_r < CNT_W'(CAPACITY)))
    else $error("insert started on a full queue");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |=> (count_r == $past(count_r) + 1'b1) && out_valid)
    else $error("insert did not grow the queue by one");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[0] == (count_r != '0))
    else $error("head cell occupancy disagrees with entry count");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (EXT_W'(rd_cnt_r) < EXT_W'(count_r)))
    else $error("read lane walk beyond live entries");

endmodule
